@@ design/plfr_pkg.sv @@
// Package for the preamble/length frame receiver.
// Holds the result status codes, register indexes, fixed widths and parameter defaults.
// No dependencies.
`default_nettype none

package plfr_pkg;

    // Parameter defaults for the top level.
    localparam int QUEUE_SLOTS_DEFAULT = 8;
    localparam int ENTRY_BYTES_DEFAULT = 64;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_BYTE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 2'd2;

    // Reset value of the length limit.
    localparam logic [7:0] MAX_LENGTH_RESET = 8'd32;

    // Framing constants.
    localparam logic [2:0] PREAMBLE_COUNT   = 3'd4;
    localparam logic [8:0] LEN_HI_INDEX     = 9'd2;
    localparam logic [8:0] LEN_LO_INDEX     = 9'd3;
    localparam logic [8:0] BYTE_INDEX_MAX   = 9'd511;
    localparam logic [16:0] LAST_PAYLOAD_OFS = 17'd3;
    localparam logic [16:0] FRAME_WINDOW_OFS = 17'd5;

    // Input request kinds.
    localparam logic REQ_RX_BYTE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        STS_NONE        = 3'd0,
        STS_FRAME_DONE  = 3'd1,
        STS_LEN_ERROR   = 3'd2,
        STS_END_MISSING = 3'd3,
        STS_QUEUE_DROP  = 3'd4
    } t_status;

    // One result item; write_enable sits in the lowest bit.
    typedef struct packed {
        t_status    status;
        logic [3:0] frames_held;
        logic [7:0] write_byte;
        logic [5:0] write_offset;
        logic [2:0] write_slot;
        logic       write_enable;
    } t_result;

    localparam int RESULT_DATA_W = 22;
    localparam int M_TDATA_W     = 24;
    localparam int S_TDATA_W     = 8;

endpackage

`default_nettype wire

@@ design/preamble_length_frame_receiver_unit.sv @@
// Top level of the preamble/length frame receiver.
// Uses plfr_pkg for status codes, register indexes and widths.
//
//  Channel   Direction  Handshake                    Payload
//  -------   ---------  ---------------------------  -----------------------------------
//  s_axis    in         s_axis_tvalid/s_axis_tready  tuser: req_type; tdata: rx_byte
//  m_axis    out        m_axis_tvalid/m_axis_tready  tuser: status; tdata: write fields
//  cfg       in         i_cfg_wr_en                  i_cfg_index, i_cfg_wdata
//
// Each request is decoded in the cycle it is accepted and its result is registered in
// the result register, or in the skid register while that one waits, so one request per
// cycle is sustained while s_axis_tready is high; the frame state updates once per request.
// A two-entry output stage (result register plus skid register) keeps s_axis_tready
// registered; it drops only while both entries hold results.
// Reset is synchronous and active low; it clears frame state, counters, configuration
// registers and the output valid bits. No clearing pass is needed.
`default_nettype none

module preamble_length_frame_receiver_unit #(
    parameter int QUEUE_SLOTS = plfr_pkg::QUEUE_SLOTS_DEFAULT,
    parameter int ENTRY_BYTES = plfr_pkg::ENTRY_BYTES_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port.
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [plfr_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [plfr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Request stream.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [plfr_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                                s_axis_tuser,  // [0] req_type
    // Result stream.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [0] write_enable, [3:1] write_slot, [9:4] write_offset, [17:10] write_byte,
    // [21:18] frames_held, [23:22] zero
    output logic [plfr_pkg::M_TDATA_W-1:0]           m_axis_tdata,
    output logic [2:0]                               m_axis_tuser   // [2:0] status
);

    localparam int SLOT_W = $clog2(QUEUE_SLOTS);
    localparam int OFF_W  = $clog2(ENTRY_BYTES);
    localparam int CNT_W  = $clog2(QUEUE_SLOTS + 1);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_SLOTS - 1);
    localparam logic [OFF_W-1:0]  OFF_LAST  = OFF_W'(ENTRY_BYTES - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_SLOTS);

    // Configuration registers.
    logic [7:0] r_start_byte;
    logic [7:0] r_end_byte;
    logic [7:0] r_max_length;

    // Frame state.
    logic [2:0]        r_preamble_run, n_preamble_run;
    logic              r_in_frame,     n_in_frame;
    logic [8:0]        r_byte_index,   n_byte_index;
    logic [15:0]       r_frame_length, n_frame_length;
    logic              r_awaiting_end, n_awaiting_end;
    logic [OFF_W-1:0]  r_fill_offset,  n_fill_offset;
    logic [SLOT_W-1:0] r_fill_slot,    n_fill_slot;
    logic [CNT_W-1:0]  r_frame_count,  n_frame_count;

    // Output stage.
    logic               r_out_valid;
    logic               r_skid_valid;
    plfr_pkg::t_result  r_out;
    plfr_pkg::t_result  r_skid;
    plfr_pkg::t_result  n_result;

    logic in_accept;
    logic out_take;
    logic req_type;
    logic [7:0] rx_byte;

    assign req_type  = s_axis_tuser;
    assign rx_byte   = s_axis_tdata[7:0];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_take  = r_out_valid && m_axis_tready;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= 8'd0;
            r_end_byte   <= 8'd0;
            r_max_length <= plfr_pkg::MAX_LENGTH_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                plfr_pkg::CFG_START_BYTE: r_start_byte <= i_cfg_wdata;
                plfr_pkg::CFG_END_BYTE:   r_end_byte   <= i_cfg_wdata;
                plfr_pkg::CFG_MAX_LENGTH: r_max_length <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame decode for the request on the input port.
    always_comb begin
        logic [8:0]  bi;
        logic [15:0] len;
        logic [16:0] bi_wide;
        logic [16:0] len_wide;
        bi       = r_byte_index;
        len      = r_frame_length;
        bi_wide  = '0;
        len_wide = '0;

        n_preamble_run = r_preamble_run;
        n_in_frame     = r_in_frame;
        n_byte_index   = r_byte_index;
        n_frame_length = r_frame_length;
        n_awaiting_end = r_awaiting_end;
        n_fill_offset  = r_fill_offset;
        n_fill_slot    = r_fill_slot;
        n_frame_count  = r_frame_count;

        n_result              = '0;
        n_result.status       = plfr_pkg::STS_NONE;

        if (req_type == plfr_pkg::REQ_RELEASE) begin
            // Consumer frees one stored frame.
            if (r_frame_count != '0) begin
                n_frame_count = r_frame_count - CNT_W'(1);
            end
        end else if (rx_byte == r_start_byte && !r_in_frame) begin
            // Preamble run while idle.
            n_frame_length = 16'd0;
            if (r_preamble_run + 3'd1 >= plfr_pkg::PREAMBLE_COUNT) begin
                n_preamble_run = plfr_pkg::PREAMBLE_COUNT;
                n_in_frame     = 1'b1;
            end else begin
                n_preamble_run = r_preamble_run + 3'd1;
            end
        end else begin
            n_preamble_run = 3'd0;
            if (r_in_frame) begin
                // Count the frame byte and pick up the length field.
                if (bi < plfr_pkg::BYTE_INDEX_MAX) begin
                    bi = bi + 9'd1;
                end
                if (bi == plfr_pkg::LEN_HI_INDEX) begin
                    len = {rx_byte, len[7:0]};
                end else if (bi == plfr_pkg::LEN_LO_INDEX) begin
                    len = {len[15:8], rx_byte};
                end
                n_byte_index   = bi;
                n_frame_length = len;
                bi_wide        = 17'(bi);
                len_wide       = 17'(len);

                if (len > 16'(r_max_length)) begin
                    // Length over the limit: back to idle.
                    n_result.status = plfr_pkg::STS_LEN_ERROR;
                    n_preamble_run  = 3'd0;
                    n_in_frame      = 1'b0;
                    n_byte_index    = 9'd0;
                    n_frame_length  = 16'd0;
                    n_awaiting_end  = 1'b0;
                    n_fill_offset   = '0;
                end else if (bi_wide < len_wide + plfr_pkg::FRAME_WINDOW_OFS) begin
                    if (r_frame_count >= CNT_FULL) begin
                        n_result.status = plfr_pkg::STS_QUEUE_DROP;
                    end else begin
                        // Store command, length and payload bytes.
                        if (!r_awaiting_end) begin
                            n_result.write_enable = 1'b1;
                            n_result.write_slot   = 3'(r_fill_slot);
                            n_result.write_offset = 6'(r_fill_offset);
                            n_result.write_byte   = rx_byte;
                        end
                        n_fill_offset = (r_fill_offset == OFF_LAST) ? '0
                                        : r_fill_offset + OFF_W'(1);

                        if (bi_wide == len_wide + plfr_pkg::LAST_PAYLOAD_OFS) begin
                            n_awaiting_end = 1'b1;
                        end else if (r_awaiting_end) begin
                            // Closing byte: commit the slot or report the mismatch.
                            if (rx_byte == r_end_byte) begin
                                n_frame_count   = r_frame_count + CNT_W'(1);
                                n_fill_slot     = (r_fill_slot == SLOT_LAST) ? '0
                                                  : r_fill_slot + SLOT_W'(1);
                                n_result.status = plfr_pkg::STS_FRAME_DONE;
                            end else begin
                                n_result.status = plfr_pkg::STS_END_MISSING;
                            end
                            n_preamble_run = 3'd0;
                            n_in_frame     = 1'b0;
                            n_byte_index   = 9'd0;
                            n_frame_length = 16'd0;
                            n_awaiting_end = 1'b0;
                            n_fill_offset  = '0;
                        end
                    end
                end
            end
        end

        n_result.frames_held = 4'(n_frame_count);
    end

    // Frame state update on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble_run <= 3'd0;
            r_in_frame     <= 1'b0;
            r_byte_index   <= 9'd0;
            r_frame_length <= 16'd0;
            r_awaiting_end <= 1'b0;
            r_fill_offset  <= '0;
            r_fill_slot    <= '0;
            r_frame_count  <= '0;
        end else if (in_accept) begin
            r_preamble_run <= n_preamble_run;
            r_in_frame     <= n_in_frame;
            r_byte_index   <= n_byte_index;
            r_frame_length <= n_frame_length;
            r_awaiting_end <= n_awaiting_end;
            r_fill_offset  <= n_fill_offset;
            r_fill_slot    <= n_fill_slot;
            r_frame_count  <= n_frame_count;
        end
    end

    // Output valid bits: result register fed directly or from the skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload registers.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_accept) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {2'b00, r_out[plfr_pkg::RESULT_DATA_W-1:0]};

    // The frame counter never passes the number of slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_count <= CNT_FULL)
        else $error("frame count above slot count");

    // The skid register is only filled behind a waiting result.
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without result entry");

    // A byte write never carries a frame event.
    a_write_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tuser == plfr_pkg::STS_NONE))
        else $error("write result with nonzero status");

    // Outside a frame the byte counter and end flag are clear.
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_byte_index == 9'd0 && !r_awaiting_end))
        else $error("frame counters set while idle");

    // A frame completion adds exactly one to the held count.
    a_commit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_result.status == plfr_pkg::STS_FRAME_DONE)
        |=> (r_frame_count == $past(r_frame_count) + CNT_W'(1)))
        else $error("frame commit did not bump the count");

endmodule

`default_nettype wire
